/* rtl/core/rpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared widths, constants and stage types of the rectangular/polar CORDIC.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ITERATIONS = 16;

  // conversion kind carried with each word
  localparam logic KIND_RECT2POLAR = 1'b0;
  localparam logic KIND_POLAR2RECT = 1'b1;

  // operands are scaled up to 32 bits; three guard bits cover the cordic gain
  localparam int INT_SHIFT = 32 - DATA_WIDTH;
  localparam int XY_W      = 35;
  localparam int Z_W       = 34;
  localparam int RES_W     = DATA_WIDTH + 1;

  // gain removal: the wide multiply is split into a low and a high part
  localparam int GAIN_W    = 29;
  localparam int LO_W      = 17;
  localparam int HI_W      = XY_W - LO_W;
  localparam int PL_W      = LO_W + GAIN_W;
  localparam int PH_W      = HI_W + GAIN_W + 1;
  localparam int SUM_W     = 64;
  localparam int OUT_SHIFT = 29 + INT_SHIFT;

  localparam logic [GAIN_W-1:0] GainQ29  = GAIN_W'(326016437);
  localparam longint            Sqrt2Q31 = 64'd3037000500;

  localparam logic [SUM_W-1:0] ROUND_OUT = SUM_W'(1) << (OUT_SHIFT - 1);
  localparam logic [31:0]      ROUND_Z   = (INT_SHIFT > 0) ? (32'd1 << (INT_SHIFT - 1)) : 32'd0;

  localparam longint SAT_HI  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint SAT_LO  = -(longint'(1) << (DATA_WIDTH - 1));
  localparam longint MAG_MAX = (((longint'(1) << (DATA_WIDTH - 1)) * Sqrt2Q31) >>> 31) + 1;

  localparam logic [Z_W-1:0] HALF_TURN = Z_W'(32'h8000_0000);

  // total cycles from an accepted word to its result strobe
  localparam int LATENCY = ITERATIONS + 4;

  // atan(2^-i), one full turn is 2^32
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                   kind;
    logic                   origin;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rpc_data_t;

  typedef struct packed {
    logic      valid;
    rpc_data_t data;
  } rpc_stage_t;

endpackage

/* rtl/core/rpc_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_prep
// Input stage: scales the operands and folds them into the cordic range.
// ----------------------------------------------------------------------------
module rpc_prep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 kind_i,
  input  logic signed [rpc_pkg::DATA_WIDTH-1:0] first_operand_i,
  input  logic signed [rpc_pkg::DATA_WIDTH-1:0] second_operand_i,
  output rpc_pkg::rpc_stage_t                  stage_o
);
  import rpc_pkg::*;

  logic signed [XY_W-1:0] a_s;
  logic signed [XY_W-1:0] b_s;
  logic [31:0]            ang;
  logic [31:0]            ang_fold;
  logic                   fold;
  rpc_data_t              data_d;
  rpc_data_t              data_q;
  logic                   valid_q;

  assign a_s = XY_W'(first_operand_i) <<< INT_SHIFT;
  assign b_s = XY_W'(second_operand_i) <<< INT_SHIFT;

  // second and third quadrant angles get turned by pi
  assign ang      = 32'($unsigned(second_operand_i)) << INT_SHIFT;
  assign fold     = ang[31] ^ ang[30];
  assign ang_fold = fold ? (ang ^ 32'h8000_0000) : ang;

  always_comb begin
    data_d.kind   = kind_i;
    data_d.origin = 1'b0;
    data_d.x      = a_s;
    data_d.y      = b_s;
    data_d.z      = '0;
    if (kind_i == KIND_RECT2POLAR) begin
      data_d.origin = (first_operand_i == '0) && (second_operand_i == '0);
      if (a_s < 0) begin
        data_d.x = -a_s;
        data_d.y = -b_s;
        data_d.z = HALF_TURN;
      end
    end else begin
      data_d.x = fold ? -a_s : a_s;
      data_d.y = '0;
      data_d.z = Z_W'($signed(ang_fold));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

/* rtl/core/rpc_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cordic
// Unrolled micro-rotations, one registered stage per iteration.
// ----------------------------------------------------------------------------
module rpc_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpc_pkg::rpc_stage_t stage_i,
  output rpc_pkg::rpc_stage_t stage_o
);
  import rpc_pkg::*;

  rpc_data_t             step_d [ITERATIONS];
  rpc_data_t             data_q [ITERATIONS];
  logic [ITERATIONS-1:0] valid_q;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    rpc_data_t              cur;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    logic                   rot_pos;

    if (i == 0) begin : g_first
      assign cur = stage_i.data;
    end else begin : g_next
      assign cur = data_q[i-1];
    end

    assign xs = $signed(cur.x) >>> i;
    assign ys = $signed(cur.y) >>> i;
    assign at = Z_W'(ATAN_TAB[i]);

    // vectoring steers on the sign of y, rotation on the sign of z
    assign rot_pos = (cur.kind == KIND_POLAR2RECT) ? !cur.z[Z_W-1] : cur.y[XY_W-1];

    always_comb begin
      step_d[i]        = cur;
      if (rot_pos) begin
        step_d[i].x = cur.x - ys;
        step_d[i].y = cur.y + xs;
        step_d[i].z = cur.z - at;
      end else begin
        step_d[i].x = cur.x + ys;
        step_d[i].y = cur.y - xs;
        step_d[i].z = cur.z + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[ITERATIONS-2:0], stage_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ITERATIONS; k++) begin
      data_q[k] <= step_d[k];
    end
  end

  assign stage_o.valid = valid_q[ITERATIONS-1];
  assign stage_o.data  = data_q[ITERATIONS-1];

endmodule

/* rtl/core/rpc_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_scale
// Gain removal, rounding and saturation over three registered stages.
// ----------------------------------------------------------------------------
module rpc_scale (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rpc_pkg::rpc_stage_t                   stage_i,
  output logic                                  done_o,
  output logic signed [rpc_pkg::RES_W-1:0]      first_result_o,
  output logic signed [rpc_pkg::DATA_WIDTH-1:0] second_result_o
);
  import rpc_pkg::*;

  // stage 1: partial products
  logic [PL_W-1:0]          plx_d, ply_d, plx_q, ply_q;
  logic signed [PH_W-1:0]   phx_d, phy_d, phx_q, phy_q;
  logic [31:0]              ang_sum;
  logic [DATA_WIDTH-1:0]    ang_d, ang1_q, ang2_q;
  logic                     kind1_q, origin1_q, kind2_q, origin2_q;
  logic                     valid1_q, valid2_q;

  // stage 2: full products with rounding
  logic signed [SUM_W-1:0]  sx_d, sy_d, sx_q, sy_q;

  // stage 3: shift and clamp
  logic signed [SUM_W-1:0]  rx, ry;
  logic signed [RES_W-1:0]      first_d;
  logic signed [DATA_WIDTH-1:0] second_d;

  assign plx_d = PL_W'(stage_i.data.x[LO_W-1:0]) * PL_W'(GainQ29);
  assign ply_d = PL_W'(stage_i.data.y[LO_W-1:0]) * PL_W'(GainQ29);
  assign phx_d = PH_W'($signed(stage_i.data.x[XY_W-1:LO_W])) * PH_W'($signed({1'b0, GainQ29}));
  assign phy_d = PH_W'($signed(stage_i.data.y[XY_W-1:LO_W])) * PH_W'($signed({1'b0, GainQ29}));

  // angle wraps modulo a full turn, round to nearest
  assign ang_sum = stage_i.data.z[31:0] + ROUND_Z;
  assign ang_d   = ang_sum[31 -: DATA_WIDTH];

  assign sx_d = (SUM_W'(phx_q) <<< LO_W) + $signed(SUM_W'(plx_q)) + $signed(ROUND_OUT);
  assign sy_d = (SUM_W'(phy_q) <<< LO_W) + $signed(SUM_W'(ply_q)) + $signed(ROUND_OUT);

  assign rx = sx_q >>> OUT_SHIFT;
  assign ry = sy_q >>> OUT_SHIFT;

  always_comb begin
    if (kind2_q == KIND_RECT2POLAR) begin
      if (origin2_q || rx < 0) begin
        first_d = '0;
      end else if (rx > MAG_MAX) begin
        first_d = RES_W'(MAG_MAX);
      end else begin
        first_d = RES_W'(rx);
      end
      second_d = origin2_q ? '0 : ang2_q;
    end else begin
      if (rx > SAT_HI) begin
        first_d = RES_W'(SAT_HI);
      end else if (rx < SAT_LO) begin
        first_d = RES_W'(SAT_LO);
      end else begin
        first_d = RES_W'(rx);
      end
      if (ry > SAT_HI) begin
        second_d = DATA_WIDTH'(SAT_HI);
      end else if (ry < SAT_LO) begin
        second_d = DATA_WIDTH'(SAT_LO);
      end else begin
        second_d = DATA_WIDTH'(ry);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      valid1_q <= stage_i.valid;
      valid2_q <= valid1_q;
      done_o   <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    plx_q           <= plx_d;
    ply_q           <= ply_d;
    phx_q           <= phx_d;
    phy_q           <= phy_d;
    ang1_q          <= ang_d;
    kind1_q         <= stage_i.data.kind;
    origin1_q       <= stage_i.data.origin;
    sx_q            <= sx_d;
    sy_q            <= sy_d;
    ang2_q          <= ang1_q;
    kind2_q         <= kind1_q;
    origin2_q       <= origin1_q;
    first_result_o  <= first_d;
    second_result_o <= second_d;
  end

endmodule

/* rtl/core/rect_polar_converter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_polar_converter_core
// Pipelined CORDIC converter between rectangular and polar form.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     start / busy     kind_i, first_operand_i, second_operand_i
//  result    done_o strobe    first_result_o, second_result_o
//
//  a word is taken in every cycle that start is high; busy stays low
//  each result strobes after its word has passed through the stages:
//  one input stage, one stage per micro-rotation, three for gain and clamp
//  reset clears only the valid bits along the pipeline
//  the result side has no back-pressure, so the pipeline never stalls
// ----------------------------------------------------------------------------
module rect_polar_converter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  kind_i,
  input  logic signed [rpc_pkg::DATA_WIDTH-1:0] first_operand_i,
  input  logic signed [rpc_pkg::DATA_WIDTH-1:0] second_operand_i,
  output logic                                  done_o,
  output logic signed [rpc_pkg::RES_W-1:0]      first_result_o,
  output logic signed [rpc_pkg::DATA_WIDTH-1:0] second_result_o
);
  import rpc_pkg::*;

  rpc_stage_t prep_stage;
  rpc_stage_t rot_stage;

  assign busy = 1'b0;

  rpc_prep u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (start & ~busy),
    .kind_i           (kind_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .stage_o          (prep_stage)
  );

  rpc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (prep_stage),
    .stage_o (rot_stage)
  );

  rpc_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (rot_stage),
    .done_o          (done_o),
    .first_result_o  (first_result_o),
    .second_result_o (second_result_o)
  );

  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted word produced no result");

  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without an accepted word");

  a_first_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (first_result_o >= SAT_LO && first_result_o <= MAG_MAX))
    else $error("first result out of range");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangular/polar CORDIC converter. A directed
// table covers the origin, the field extremes, both half planes and the
// quadrant boundaries of the angle. About 1650 random words follow, with
// idle bursts on the input side. Every result is compared field by field
// against a golden table value or the bench's bit-accurate CORDIC predictor.
// ----------------------------------------------------------------------------
module tb;
  import rpc_pkg::*;

  localparam int DW            = rpc_pkg::DATA_WIDTH;
  localparam int RW            = rpc_pkg::RES_W;
  localparam int RAND_WORDS    = 1650;
  localparam int QUIET_TAIL    = 300;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic signed [RW-1:0] first_res;
    logic signed [DW-1:0] second_res;
  } conv_result_t;

  typedef struct packed {
    logic                 kind;
    logic signed [DW-1:0] op_a;
    logic signed [DW-1:0] op_b;
    logic                 golden;
    logic signed [RW-1:0] gold_first;
    logic signed [DW-1:0] gold_second;
  } stim_row_t;

  // golden values only where the answer is exact: zero vector or zero radius
  localparam stim_row_t DirRows [23] = '{
    '{KIND_RECT2POLAR,      0,      0, 1'b1, 0, 0},
    '{KIND_RECT2POLAR,  32767,      0, 1'b0, 0, 0},
    '{KIND_RECT2POLAR, -32768,      0, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,      0,  32767, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,      0, -32768, 1'b0, 0, 0},
    '{KIND_RECT2POLAR, -32768, -32768, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,  32767,  32767, 1'b0, 0, 0},
    '{KIND_RECT2POLAR, -32768,  32767, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,  32767, -32768, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,     -1,      0, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,      1,     -1, 1'b0, 0, 0},
    '{KIND_RECT2POLAR,     -1,     -1, 1'b0, 0, 0},
    '{KIND_POLAR2RECT,      0,      0, 1'b1, 0, 0},
    '{KIND_POLAR2RECT,      0, -32768, 1'b1, 0, 0},
    '{KIND_POLAR2RECT,  32767,      0, 1'b0, 0, 0},
    '{KIND_POLAR2RECT, -32768,      0, 1'b0, 0, 0},
    '{KIND_POLAR2RECT, -32768, -32768, 1'b0, 0, 0},
    '{KIND_POLAR2RECT,  32767,  16384, 1'b0, 0, 0},
    '{KIND_POLAR2RECT,  32767,  16383, 1'b0, 0, 0},
    '{KIND_POLAR2RECT,  32767, -16384, 1'b0, 0, 0},
    '{KIND_POLAR2RECT,  32767, -16385, 1'b0, 0, 0},
    '{KIND_POLAR2RECT, -32768,   8192, 1'b0, 0, 0},
    '{KIND_POLAR2RECT,  12345,  24576, 1'b0, 0, 0}
  };

  localparam logic signed [DW-1:0] EXTREME_VALS [6] = '{-32768, -32767, -1, 0, 1, 32767};

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 start            = 1'b0;
  logic                 kind_i           = 1'b0;
  logic signed [DW-1:0] first_operand_i  = '0;
  logic signed [DW-1:0] second_operand_i = '0;
  logic                 busy;
  logic                 done_o;
  logic signed [RW-1:0] first_result_o;
  logic signed [DW-1:0] second_result_o;

  // golden value riding along with the word currently on the inputs
  logic                 golden_hold  = 1'b0;
  conv_result_t         golden_value = '0;

  conv_result_t pending_results[$];
  int           mismatches   = 0;
  int           rect_words   = 0;
  int           polar_words  = 0;
  int           results_seen = 0;
  int           idle_bursts  = 0;
  int           idle_cycles  = 0;

  always #5 clk_i = ~clk_i;

  rect_polar_converter_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .done_o           (done_o),
    .first_result_o   (first_result_o),
    .second_result_o  (second_result_o)
  );

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // remove the cordic gain and drop the internal scaling, rounding half up
  function automatic longint gain_correct(longint v);
    longint prod;
    prod = v * longint'(rpc_pkg::GainQ29);
    return (prod + (longint'(1) << (rpc_pkg::OUT_SHIFT - 1))) >>> rpc_pkg::OUT_SHIFT;
  endfunction

  function automatic conv_result_t cordic_convert(logic kind, logic signed [DW-1:0] op_a,
                                                  logic signed [DW-1:0] op_b);
    conv_result_t res;
    longint       x, y, xs, ys, ang;
    logic [31:0]  z;
    res = '0;
    x   = longint'(op_a) <<< rpc_pkg::INT_SHIFT;
    y   = longint'(op_b) <<< rpc_pkg::INT_SHIFT;
    if (kind == KIND_RECT2POLAR) begin
      if (op_a == 0 && op_b == 0) return res;
      z = '0;
      // left half plane: turn the vector by pi first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < rpc_pkg::ITERATIONS; i++) begin
        xs = x >>> (i % 32);
        ys = y >>> (i % 32);
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += rpc_pkg::ATAN_TAB[i % 32];
        end else begin
          x -= ys;
          y += xs;
          z -= rpc_pkg::ATAN_TAB[i % 32];
        end
      end
      res.first_res  = RW'(clamp(gain_correct(x), 0, rpc_pkg::MAG_MAX));
      z              = (z + rpc_pkg::ROUND_Z) >> rpc_pkg::INT_SHIFT;
      res.second_res = z[DW-1:0];
    end else begin
      z = 32'(op_b) << rpc_pkg::INT_SHIFT;
      y = 0;
      // second and third quadrant: rotate by pi and flip the radius
      if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
        z += 32'h8000_0000;
        x = -x;
      end
      ang = longint'(signed'(z));
      for (int i = 0; i < rpc_pkg::ITERATIONS; i++) begin
        xs = x >>> (i % 32);
        ys = y >>> (i % 32);
        if (ang >= 0) begin
          x -= ys;
          y += xs;
          ang -= longint'(rpc_pkg::ATAN_TAB[i % 32]);
        end else begin
          x += ys;
          y -= xs;
          ang += longint'(rpc_pkg::ATAN_TAB[i % 32]);
        end
      end
      res.first_res  = RW'(clamp(gain_correct(x), rpc_pkg::SAT_LO, rpc_pkg::SAT_HI));
      res.second_res = DW'(clamp(gain_correct(y), rpc_pkg::SAT_LO, rpc_pkg::SAT_HI));
    end
    return res;
  endfunction

  task automatic send_word(logic kind, logic signed [DW-1:0] op_a, logic signed [DW-1:0] op_b,
                           logic golden, conv_result_t gold);
    @(negedge clk_i);
    start            <= 1'b1;
    kind_i           <= kind;
    first_operand_i  <= op_a;
    second_operand_i <= op_b;
    golden_hold      <= golden;
    golden_value     <= gold;
    do @(posedge clk_i); while (busy);
  endtask

  // idle cycles carry junk on the operands, which must be ignored
  task automatic idle_gap(int cycles);
    idle_bursts++;
    repeat (cycles) begin
      @(negedge clk_i);
      start            <= 1'b0;
      kind_i           <= 1'($urandom);
      first_operand_i  <= DW'($urandom);
      second_operand_i <= DW'($urandom);
    end
  endtask

  // accept, predict and check, all on the rising edge
  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni && start && !busy) begin
      pending_results.push_back(golden_hold ? golden_value :
                                cordic_convert(kind_i, first_operand_i, second_operand_i));
      if (kind_i == KIND_RECT2POLAR) rect_words++;
      else polar_words++;
    end
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %0d %0d", first_result_o, second_result_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (first_result_o !== want.first_res) begin
          $error("first_result: expected %0d, got %0d", want.first_res, first_result_o);
          mismatches++;
        end
        if (second_result_o !== want.second_res) begin
          $error("second_result: expected %0d, got %0d", want.second_res, second_result_o);
          mismatches++;
        end
      end
    end
    if ((rst_ni && start && !busy) || (rst_ni && done_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without progress", idle_cycles);
      $display("rect_polar_converter_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic                 kind;
    logic signed [DW-1:0] op_a, op_b;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirRows[i]) begin
      send_word(DirRows[i].kind, DirRows[i].op_a, DirRows[i].op_b, DirRows[i].golden,
                '{DirRows[i].gold_first, DirRows[i].gold_second});
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      kind = 1'($urandom_range(0, 1));
      op_a = DW'($urandom);
      op_b = DW'($urandom);
      case ($urandom_range(0, 9))
        5: begin
          op_a = DW'(int'($urandom_range(0, 16)) - 8);
          op_b = DW'(int'($urandom_range(0, 16)) - 8);
        end
        6: begin
          op_a = EXTREME_VALS[$urandom_range(0, 5)];
          op_b = EXTREME_VALS[$urandom_range(0, 5)];
        end
        7: begin
          // angles right around the quadrant boundaries
          kind = KIND_POLAR2RECT;
          op_b = DW'(int'($urandom_range(0, 3) << (DW - 2)) + int'($urandom_range(0, 8)) - 4);
        end
        8: begin
          // long vectors near the corners, where the magnitude clamps
          op_a = DW'(($urandom_range(0, 1) ? 32'h7FF0 : 32'h8000) + $urandom_range(0, 15));
          op_b = DW'(($urandom_range(0, 1) ? 32'h7FF0 : 32'h8000) + $urandom_range(0, 15));
        end
        9: begin
          if ($urandom_range(0, 1)) op_a = '0;
          else op_b = '0;
        end
        default: ;
      endcase
      send_word(kind, op_a, op_b, 1'b0, '0);
      if (n < RAND_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 10));
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (rpc_pkg::LATENCY + 4) @(posedge clk_i);

    $display("covered %0d rect-to-polar and %0d polar-to-rect words, %0d results compared",
             rect_words, polar_words, results_seen);
    $display("input side idled in %0d bursts, %0d field mismatches", idle_bursts, mismatches);
    if (mismatches == 0) begin
      $display("rect_polar_converter_core: match");
    end else begin
      $display("rect_polar_converter_core: mismatch");
    end
    $finish;
  end

endmodule
